// File: rtl/psd_pkg.sv
package psd_pkg;

	localparam int CW        = 16;              // coordinate width
	localparam int FRAC_BITS = 8;
	localparam int DIST_BITS = CW + 1 + FRAC_BITS;
	localparam int THR_BITS  = 25;
	localparam int DW        = CW + 1;          // coordinate difference
	localparam int SQW       = 2 * DW;          // product of two differences
	localparam int LENW      = SQW + 1;         // sum of two squares
	localparam int CRW       = SQW + 2;         // dot / cross product
	localparam int HW        = CRW / 2;         // half of |cross| for split square
	localparam int NW        = 2 * CRW + 2 * FRAC_BITS;
	localparam int QW        = 2 * DIST_BITS;   // quotient = radicand
	localparam int DENW      = LENW;
	localparam int RMW       = DIST_BITS + 2;   // root remainder

	localparam int IN_BYTES  = (6 * CW + THR_BITS + 7) / 8;
	localparam int OUT_BYTES = (DIST_BITS + 3 + 7) / 8;

	typedef enum logic [1:0] {
		REG_INTERIOR = 2'd0,
		REG_BEFORE   = 2'd1,
		REG_PAST     = 2'd2,
		REG_ZERO     = 2'd3
	} region_t;

	typedef struct packed {
		region_t region;
		logic    near;
	} tag_t;

endpackage

// File: rtl/point_segment_distance.sv
// Point to segment distance, fully pipelined.
//
// s_* : one beat per query (query, start, end points and near threshold).
// m_* : one beat per result: distance (8 fraction bits, rounded down), near
//       flag and region (interior, before start, past end, zero length).
//
// Throughput is one beat per cycle unless stalled. From the input beat to the
// output beat there are 6 stages of differences, products and selection,
// 50 stages of restoring division (one quotient bit each) and 25 stages of
// digit-by-digit square root (one root bit each); the last root stage is the
// output register.
//
// When m_tready is low while a result is held, the whole pipeline freezes
// and s_tready drops; nothing is lost or repeated. Bubbles are not squeezed out.
// Reset clears the stage valid bits only; the block is ready right after.
module point_segment_distance (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// query_x, query_y, start_x, start_y, end_x, end_y, threshold
	input  logic [8*psd_pkg::IN_BYTES-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// seg_distance, is_near, region
	output logic [8*psd_pkg::OUT_BYTES-1:0]  m_tdata
);
	import psd_pkg::*;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [CW-1:0] qx, qy, sx, sy, ex, ey;
	logic [THR_BITS-1:0]  thr;
	assign qx  = s_tdata[0*CW +: CW];
	assign qy  = s_tdata[1*CW +: CW];
	assign sx  = s_tdata[2*CW +: CW];
	assign sy  = s_tdata[3*CW +: CW];
	assign ex  = s_tdata[4*CW +: CW];
	assign ey  = s_tdata[5*CW +: CW];
	assign thr = s_tdata[6*CW +: THR_BITS];

	// stage 1: differences
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, wx_s1, wy_s1, vx_s1, vy_s1;
	logic [THR_BITS-1:0]  thr_s1;

	// stage 2: products
	logic                  v_s2;
	logic signed [SQW-1:0] dxdx_s2, dydy_s2, wxdx_s2, wydy_s2, wxdy_s2, wydx_s2;
	logic signed [SQW-1:0] wxwx_s2, wywy_s2, vxvx_s2, vyvy_s2;
	logic [QW-1:0]         thr2_s2;

	// stage 3: sums
	logic                  v_s3;
	logic [LENW-1:0]       len2_s3, pw_s3, pv_s3;
	logic signed [CRW-1:0] dot_s3, cross_s3;
	logic [QW-1:0]         thr2_s3;

	// stage 4: region choice
	logic            v_s4;
	region_t         region_s4;
	logic [CRW-1:0]  cmag_s4;
	logic [LENW-1:0] dsq_s4;
	logic [DENW-1:0] den_s4;
	logic [QW-1:0]   thr2_s4;

	// stage 5: partial products of |cross|^2
	logic              v_s5;
	region_t           region_s5;
	logic [2*HW-1:0]   hh_s5, hl_s5, ll_s5;
	logic [LENW-1:0]   dsq_s5;
	logic [DENW-1:0]   den_s5;
	logic [QW-1:0]     thr2_s5;

	// stage 6: scaled numerator
	logic            v_s6;
	region_t         region_s6;
	logic [NW-1:0]   num_s6;
	logic [DENW-1:0] den_s6;
	logic [QW-1:0]   thr2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	logic [CRW-1:0] cabs;
	logic           neg_dot, past_end, zero_len;
	logic [NW-1:0]  csq;
	assign cabs     = cross_s3[CRW-1] ? $unsigned(-cross_s3) : $unsigned(cross_s3);
	assign zero_len = len2_s3 == '0;
	assign neg_dot  = dot_s3[CRW-1];
	assign past_end = $unsigned(dot_s3) > CRW'(len2_s3);
	assign csq      = (NW'(hh_s5) << (2*HW)) + (NW'(hl_s5) << (HW+1)) + NW'(ll_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DW'(ex) - DW'(sx);
			dy_s1  <= DW'(ey) - DW'(sy);
			wx_s1  <= DW'(qx) - DW'(sx);
			wy_s1  <= DW'(qy) - DW'(sy);
			vx_s1  <= DW'(qx) - DW'(ex);
			vy_s1  <= DW'(qy) - DW'(ey);
			thr_s1 <= thr;

			dxdx_s2 <= dx_s1 * dx_s1;
			dydy_s2 <= dy_s1 * dy_s1;
			wxdx_s2 <= wx_s1 * dx_s1;
			wydy_s2 <= wy_s1 * dy_s1;
			wxdy_s2 <= wx_s1 * dy_s1;
			wydx_s2 <= wy_s1 * dx_s1;
			wxwx_s2 <= wx_s1 * wx_s1;
			wywy_s2 <= wy_s1 * wy_s1;
			vxvx_s2 <= vx_s1 * vx_s1;
			vyvy_s2 <= vy_s1 * vy_s1;
			thr2_s2 <= QW'(thr_s1) * QW'(thr_s1);

			// squares are never negative
			len2_s3  <= LENW'($unsigned(dxdx_s2)) + LENW'($unsigned(dydy_s2));
			pw_s3    <= LENW'($unsigned(wxwx_s2)) + LENW'($unsigned(wywy_s2));
			pv_s3    <= LENW'($unsigned(vxvx_s2)) + LENW'($unsigned(vyvy_s2));
			dot_s3   <= CRW'(wxdx_s2) + CRW'(wydy_s2);
			cross_s3 <= CRW'(wxdy_s2) - CRW'(wydx_s2);
			thr2_s3  <= thr2_s2;

			cmag_s4 <= cabs;
			thr2_s4 <= thr2_s3;
			den_s4  <= DENW'(1);
			dsq_s4  <= pw_s3;
			if (zero_len) begin
				region_s4 <= REG_ZERO;
			end else if (neg_dot) begin
				region_s4 <= REG_BEFORE;
			end else if (past_end) begin
				region_s4 <= REG_PAST;
				dsq_s4    <= pv_s3;
			end else begin
				region_s4 <= REG_INTERIOR;
				den_s4    <= len2_s3;
			end

			hh_s5     <= cmag_s4[CRW-1:HW] * cmag_s4[CRW-1:HW];
			hl_s5     <= cmag_s4[CRW-1:HW] * cmag_s4[HW-1:0];
			ll_s5     <= cmag_s4[HW-1:0] * cmag_s4[HW-1:0];
			region_s5 <= region_s4;
			dsq_s5    <= dsq_s4;
			den_s5    <= den_s4;
			thr2_s5   <= thr2_s4;

			num_s6    <= ((region_s5 == REG_INTERIOR) ? csq : NW'(dsq_s5)) << (2*FRAC_BITS);
			region_s6 <= region_s5;
			den_s6    <= den_s5;
			thr2_s6   <= thr2_s5;
		end
	end

	logic          div_valid;
	logic [QW-1:0] quo;
	tag_t          div_tag;

	psd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (num_s6),
		.den       (den_s6),
		.thr2      (thr2_s6),
		.region    (region_s6),
		.out_valid (div_valid),
		.quo       (quo),
		.tag       (div_tag)
	);

	logic [DIST_BITS-1:0] root;
	tag_t                 res_tag;

	psd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.rad       (quo),
		.tag_in    (div_tag),
		.out_valid (m_tvalid),
		.root      (root),
		.tag_out   (res_tag)
	);

	assign m_tdata = (8*OUT_BYTES)'({res_tag.region, res_tag.near, root});

	// an accepted beat lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted beat missing from stage 1");

	// a frozen pipe keeps its stage 6 item
	a_stall_s6: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !en |=> v_s6 && $stable(num_s6))
		else $error("stage 6 item lost during stall");

	// stage 4 divisor is one unless the projection is interior
	a_den_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && region_s4 != REG_INTERIOR |-> den_s4 == DENW'(1))
		else $error("endpoint distance with divisor other than one");

endmodule

// File: rtl/psd_div.sv
module psd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [psd_pkg::NW-1:0]      num,
	input  logic [psd_pkg::DENW-1:0]    den,
	input  logic [psd_pkg::QW-1:0]      thr2,
	input  psd_pkg::region_t            region,
	output logic                        out_valid,
	output logic [psd_pkg::QW-1:0]      quo,
	output psd_pkg::tag_t               tag
);
	import psd_pkg::*;

	// one quotient bit per stage; stage 0 is the input
	logic            v_s   [QW+1];
	logic [DENW-1:0] rem_s [QW+1];
	logic [QW-1:0]   lo_s  [QW+1];
	logic [QW-1:0]   q_s   [QW+1];
	logic [DENW-1:0] den_s [QW+1];
	logic [QW-1:0]   thr_s [QW+1];
	region_t         reg_s [QW+1];

	// quotient fits QW bits, so the upper part of num is already below den
	assign v_s[0]   = in_valid;
	assign rem_s[0] = num[QW+DENW-1:QW];
	assign lo_s[0]  = num[QW-1:0];
	assign q_s[0]   = '0;
	assign den_s[0] = den;
	assign thr_s[0] = thr2;
	assign reg_s[0] = region;

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [DENW:0] t, diff;
		logic          ge;

		assign t    = {rem_s[k-1], lo_s[k-1][QW-1]};
		assign ge   = t >= {1'b0, den_s[k-1]};
		assign diff = t - {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DENW-1:0] : t[DENW-1:0];
				lo_s[k]  <= {lo_s[k-1][QW-2:0], 1'b0};
				q_s[k]   <= {q_s[k-1][QW-2:0], ge};
				den_s[k] <= den_s[k-1];
				thr_s[k] <= thr_s[k-1];
				reg_s[k] <= reg_s[k-1];
			end
		end
	end

	// exact: num/den <= thr^2 iff floor below, or equal with no remainder
	assign out_valid  = v_s[QW];
	assign quo        = q_s[QW];
	assign tag.region = reg_s[QW];
	assign tag.near   = (q_s[QW] < thr_s[QW]) ||
		((q_s[QW] == thr_s[QW]) && (rem_s[QW] == '0));

endmodule

// File: rtl/psd_sqrt.sv
module psd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [psd_pkg::QW-1:0]        rad,
	input  psd_pkg::tag_t                 tag_in,
	output logic                          out_valid,
	output logic [psd_pkg::DIST_BITS-1:0] root,
	output psd_pkg::tag_t                 tag_out
);
	import psd_pkg::*;

	// two radicand bits and one root bit per stage
	logic                 v_s    [DIST_BITS+1];
	logic [QW-1:0]        rad_s  [DIST_BITS+1];
	logic [RMW-1:0]       rem_s  [DIST_BITS+1];
	logic [DIST_BITS-1:0] root_s [DIST_BITS+1];
	tag_t                 tag_s  [DIST_BITS+1];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = tag_in;

	for (genvar k = 1; k <= DIST_BITS; k++) begin : g_stage
		logic [RMW-1:0] t, trial;
		logic           ge;

		assign t     = {rem_s[k-1][RMW-3:0], rad_s[k-1][QW-2*k +: 2]};
		assign trial = {root_s[k-1], 2'b01};
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_s[k-1];
				rem_s[k]  <= ge ? t - trial : t;
				root_s[k] <= {root_s[k-1][DIST_BITS-2:0], ge};
				tag_s[k]  <= tag_s[k-1];
			end
		end
	end

	assign out_valid = v_s[DIST_BITS];
	assign root      = root_s[DIST_BITS];
	assign tag_out   = tag_s[DIST_BITS];

endmodule
